@@ design/ghrf_pkg.sv @@
package ghrf_pkg;

    localparam int GYRO_W    = 16;
    localparam int ELAPSED_W = 20;
    localparam int ECHO_W    = 13;
    localparam int BIAS_W    = 20;
    localparam int DB_W      = 19;
    localparam int HEAD_W    = 64;
    localparam int RATE_W    = 21;
    localparam int PROD_W    = RATE_W + ELAPSED_W + 1;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_GYRO_BIAS = 2'd0,
        REG_DEADBAND  = 2'd1,
        REG_EMERGENCY = 2'd2,
        REG_NONE      = 2'd3
    } reg_index_t;

    localparam logic [ECHO_W-1:0] EMERGENCY_RESET = 13'd294;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE,
        ST_MUL,
        ST_ACC,
        ST_SUM,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic rate;
        logic mul;
        logic acc;
        logic sum_step;
        logic div_start;
        logic fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic hist_write;
        logic sum_last;
        logic div_done;
    } sts_t;

endpackage

@@ design/ghrf_div.sv @@
module ghrf_div #(
    parameter int DVD_W = 16,
    parameter int DVS_W = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DVS_W:0]   trial;

    // Restoring division, one quotient bit per cycle, most significant first.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DVD_W);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, divisor})
            begin
                rem_next = DVS_W'(trial - {1'b0, divisor});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == '0);

endmodule

@@ design/ghrf_ctrl.sv @@
module ghrf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  ghrf_pkg::sts_t sts,
    output ghrf_pkg::cmd_t cmd
);

    import ghrf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                cmd.rate   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.hist_write ? ST_SUM : ST_OUT;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_last)
                begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ design/ghrf_dp.sv @@
module ghrf_dp #(
    parameter int HISTORY_DEPTH = 5,
    parameter int SONAR_PERIOD  = 5
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ghrf_pkg::cmd_t                         cmd,
    output ghrf_pkg::sts_t                         sts,
    input  logic signed [ghrf_pkg::BIAS_W-1:0]     gyro_bias,
    input  logic        [ghrf_pkg::DB_W-1:0]       deadband,
    input  logic        [ghrf_pkg::ECHO_W-1:0]     emergency_echo_us,
    input  logic signed [ghrf_pkg::GYRO_W-1:0]     gyro_raw,
    input  logic                                   gyro_ok,
    input  logic        [ghrf_pkg::ELAPSED_W-1:0]  elapsed_us,
    input  logic        [ghrf_pkg::ECHO_W-1:0]     echo_us,
    input  logic                                   motor_running,
    output logic signed [ghrf_pkg::HEAD_W-1:0]     heading_acc,
    output logic        [ghrf_pkg::ECHO_W-1:0]     echo_avg_us,
    output logic                                   range_ok,
    output logic                                   stop_request,
    output logic                                   sonar_step
);

    import ghrf_pkg::*;

    localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = ECHO_W + CNT_W;
    localparam int TICK_W = (SONAR_PERIOD > 1) ? $clog2(SONAR_PERIOD) : 1;

    logic signed [GYRO_W-1:0]    raw_reg;
    logic                        ok_reg;
    logic        [ELAPSED_W-1:0] elapsed_reg;
    logic        [ECHO_W-1:0]    echo_reg;
    logic                        motor_reg;

    logic signed [RATE_W-1:0]    rate_reg;
    logic signed [PROD_W-1:0]    prod_reg;

    logic signed [HEAD_W-1:0]    heading_reg;
    logic signed [HEAD_W-1:0]    heading_next;
    logic        [TICK_W-1:0]    tick_reg;
    logic        [IDX_W-1:0]     slot_reg;
    logic        [HISTORY_DEPTH-1:0] hvalid_reg;
    logic        [ECHO_W-1:0]    hist_reg [HISTORY_DEPTH];
    logic        [ECHO_W-1:0]    range_reg;
    logic                        flag_reg;
    logic                        stop_reg;
    logic                        sonar_reg;

    logic        [IDX_W-1:0]     idx_reg;
    logic        [SUM_W-1:0]     sum_reg;
    logic        [CNT_W-1:0]     cnt_reg;

    logic signed [RATE_W-1:0]    rate_raw;
    logic        [RATE_W-1:0]    rate_mag;
    logic signed [HEAD_W:0]      sat_sum;
    logic                        tick_wrap;
    logic                        active;

    logic        [SUM_W-1:0]     quotient;
    logic                        div_done;

    ghrf_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        rate_raw = RATE_W'(raw_reg) * RATE_W'(16) - RATE_W'(gyro_bias);
        rate_mag = rate_raw[RATE_W-1] ? RATE_W'(-rate_raw) : RATE_W'(rate_raw);
        sat_sum  = {heading_reg[HEAD_W-1], heading_reg}
                 + (HEAD_W + 1)'(prod_reg);
        if (sat_sum[HEAD_W] != sat_sum[HEAD_W-1])
        begin
            heading_next = sat_sum[HEAD_W] ? {1'b1, {(HEAD_W-1){1'b0}}}
                                           : {1'b0, {(HEAD_W-1){1'b1}}};
        end
        else
        begin
            heading_next = sat_sum[HEAD_W-1:0];
        end
        active    = (elapsed_reg != '0);
        tick_wrap = (tick_reg == TICK_W'(SONAR_PERIOD - 1));
    end

    assign sts.hist_write = active && tick_wrap && (echo_reg != '0);
    assign sts.sum_last   = (idx_reg == IDX_W'(HISTORY_DEPTH - 1));
    assign sts.div_done   = div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg     <= gyro_raw;
            ok_reg      <= gyro_ok;
            elapsed_reg <= elapsed_us;
            echo_reg    <= echo_us;
            motor_reg   <= motor_running;
        end
        if (cmd.rate)
        begin
            if (!ok_reg || (rate_mag < RATE_W'(deadband)))
            begin
                rate_reg <= '0;
            end
            else
            begin
                rate_reg <= rate_raw;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= rate_reg * $signed({1'b0, elapsed_reg});
        end
        if (cmd.acc && sts.hist_write)
        begin
            hist_reg[slot_reg] <= echo_reg;
        end
        if (cmd.out_load)
        begin
            heading_acc  <= heading_reg;
            echo_avg_us  <= flag_reg ? range_reg : '0;
            range_ok     <= flag_reg;
            stop_request <= stop_reg;
            sonar_step   <= sonar_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg <= '0;
            tick_reg    <= '0;
            slot_reg    <= '0;
            hvalid_reg  <= '0;
            range_reg   <= '0;
            flag_reg    <= 1'b0;
            stop_reg    <= 1'b0;
            sonar_reg   <= 1'b0;
            idx_reg     <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.acc)
            begin
                heading_reg <= heading_next;
                stop_reg    <= 1'b0;
                sonar_reg   <= active && tick_wrap;
                idx_reg     <= '0;
                sum_reg     <= '0;
                cnt_reg     <= '0;
                if (active)
                begin
                    tick_reg <= tick_wrap ? '0 : tick_reg + 1'b1;
                    if (tick_wrap && (echo_reg == '0))
                    begin
                        range_reg <= '0;
                        flag_reg  <= 1'b0;
                    end
                end
                if (sts.hist_write)
                begin
                    hvalid_reg[slot_reg] <= 1'b1;
                    slot_reg <= (slot_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                                        : slot_reg + 1'b1;
                end
            end
            if (cmd.sum_step)
            begin
                if (hvalid_reg[idx_reg])
                begin
                    sum_reg <= sum_reg + SUM_W'(hist_reg[idx_reg]);
                    cnt_reg <= cnt_reg + 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.fin)
            begin
                if (cnt_reg != '0)
                begin
                    range_reg <= quotient[ECHO_W-1:0];
                    flag_reg  <= 1'b1;
                    stop_reg  <= motor_reg && (quotient[ECHO_W-1:0] < emergency_echo_us);
                end
                else
                begin
                    range_reg <= '0;
                    flag_reg  <= 1'b0;
                end
            end
        end
    end

endmodule

@@ design/gyro_heading_and_range_filter.sv @@
// Integrates the gyro Z rate into a saturating 64-bit heading accumulator and keeps
// a moving average of the ultrasonic echo width taken every SONAR_PERIOD-th tick,
// raising a stop request when a valid average falls below the emergency threshold
// while the motor runs. Each tick request yields exactly one result. A tick that
// does not add an echo to the history passes through the load, rate, multiply,
// accumulate and output states; one that does also runs the serial sweep over the
// history and the bit-per-cycle divider that forms the average. A new request is
// taken while a finished result still waits in the output register.
module gyro_heading_and_range_filter #(
    parameter int HISTORY_DEPTH = 5,
    parameter int SONAR_PERIOD  = 5
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic        [ghrf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic        [ghrf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic        [ghrf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                      pready,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [ghrf_pkg::GYRO_W-1:0]        gyro_raw,
    input  logic                                      gyro_ok,
    input  logic        [ghrf_pkg::ELAPSED_W-1:0]     elapsed_us,
    input  logic        [ghrf_pkg::ECHO_W-1:0]        echo_us,
    input  logic                                      motor_running,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [ghrf_pkg::HEAD_W-1:0]        heading_acc,
    output logic        [ghrf_pkg::ECHO_W-1:0]        echo_avg_us,
    output logic                                      range_ok,
    output logic                                      stop_request,
    output logic                                      sonar_step
);

    import ghrf_pkg::*;

    logic signed [BIAS_W-1:0] bias_reg;
    logic        [DB_W-1:0]   deadband_reg;
    logic        [ECHO_W-1:0] emergency_reg;
    reg_index_t               reg_idx;
    logic                     cfg_write;
    cmd_t                     cmd;
    sts_t                     sts;

    assign reg_idx   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg      <= '0;
            deadband_reg  <= '0;
            emergency_reg <= EMERGENCY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_GYRO_BIAS: bias_reg      <= pwdata[BIAS_W-1:0];
                REG_DEADBAND:  deadband_reg  <= pwdata[DB_W-1:0];
                REG_EMERGENCY: emergency_reg <= pwdata[ECHO_W-1:0];
                REG_NONE:      ;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GYRO_BIAS: prdata = APB_DATA_W'(bias_reg);
            REG_DEADBAND:  prdata = APB_DATA_W'(deadband_reg);
            REG_EMERGENCY: prdata = APB_DATA_W'(emergency_reg);
            REG_NONE:      prdata = '0;
            default:       prdata = '0;
        endcase
    end

    ghrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ghrf_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SONAR_PERIOD  (SONAR_PERIOD)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .gyro_bias         (bias_reg),
        .deadband          (deadband_reg),
        .emergency_echo_us (emergency_reg),
        .gyro_raw          (gyro_raw),
        .gyro_ok           (gyro_ok),
        .elapsed_us        (elapsed_us),
        .echo_us           (echo_us),
        .motor_running     (motor_running),
        .heading_acc       (heading_acc),
        .echo_avg_us       (echo_avg_us),
        .range_ok          (range_ok),
        .stop_request      (stop_request),
        .sonar_step        (sonar_step)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import ghrf_pkg::*;

    localparam int SONAR_PERIOD  = 5;
    localparam int HISTORY_DEPTH = 5;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_LIMIT   = 100;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

    typedef struct packed {
        logic signed [GYRO_W-1:0] raw;
        logic                     ok;
        logic [ELAPSED_W-1:0]     elapsed;
        logic [ECHO_W-1:0]        echo;
        logic                     motor;
    } tick_in_t;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic [ECHO_W-1:0]        avg;
        logic                     rok;
        logic                     stop;
        logic                     sonar;
    } tick_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [GYRO_W-1:0] gyro_raw = '0;
    logic gyro_ok = 1'b0;
    logic [ELAPSED_W-1:0] elapsed_us = '0;
    logic [ECHO_W-1:0] echo_us = '0;
    logic motor_running = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [HEAD_W-1:0] heading_acc;
    logic [ECHO_W-1:0] echo_avg_us;
    logic range_ok;
    logic stop_request;
    logic sonar_step;

    // Predicted block state and register copies.
    longint              bias_cfg;
    logic [DB_W-1:0]     deadband_cfg;
    logic [ECHO_W-1:0]   emerg_cfg;
    logic signed [63:0]  heading_sum;
    logic [ECHO_W-1:0]   echo_hist [HISTORY_DEPTH];
    logic                echo_seen [HISTORY_DEPTH];
    int                  hist_slot;
    int                  tick_phase;
    logic [ECHO_W-1:0]   range_us;
    logic                range_valid;

    tick_result_t awaited_ticks[$];
    int           mismatches = 0;
    stall_mode_t  stall_mode = STALL_NONE;
    bit           gaps_on = 1'b0;
    int           burst_left = 0;
    int           beat = 0;
    logic         hold_on;
    event         hold_go;

    gyro_heading_and_range_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .gyro_raw      (gyro_raw),
        .gyro_ok       (gyro_ok),
        .elapsed_us    (elapsed_us),
        .echo_us       (echo_us),
        .motor_running (motor_running),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .heading_acc   (heading_acc),
        .echo_avg_us   (echo_avg_us),
        .range_ok      (range_ok),
        .stop_request  (stop_request),
        .sonar_step    (sonar_step)
    );

    always #10 clk = ~clk;

    function automatic void clear_model();
        bias_cfg = 0;
        deadband_cfg = '0;
        emerg_cfg = EMERGENCY_RESET;
        heading_sum = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            echo_hist[i] = '0;
            echo_seen[i] = 1'b0;
        end
        hist_slot = 0;
        tick_phase = 0;
        range_us = '0;
        range_valid = 1'b0;
    endfunction

    function automatic tick_result_t filter_tick(input tick_in_t t);
        tick_result_t r;
        longint rate;
        longint mag;
        logic signed [63:0] prod;
        logic signed [63:0] sum64;
        int unsigned total;
        int unsigned cnt;
        r.stop = 1'b0;
        r.sonar = 1'b0;
        if (t.elapsed != 0)
        begin
            if (t.ok)
            begin
                rate = longint'(t.raw) * 16 - bias_cfg;
                mag = (rate < 0) ? -rate : rate;
                if (mag < longint'(deadband_cfg))
                    rate = 0;
                prod = rate * longint'(t.elapsed);
                sum64 = heading_sum + prod;
                if (heading_sum[63] == prod[63] && sum64[63] != heading_sum[63])
                    sum64 = heading_sum[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                heading_sum = sum64;
            end
            tick_phase++;
            if (tick_phase >= SONAR_PERIOD)
            begin
                tick_phase = 0;
                r.sonar = 1'b1;
                if (t.echo != 0)
                begin
                    echo_hist[hist_slot] = t.echo;
                    echo_seen[hist_slot] = 1'b1;
                    hist_slot = (hist_slot + 1) % HISTORY_DEPTH;
                    total = 0;
                    cnt = 0;
                    for (int i = 0; i < HISTORY_DEPTH; i++)
                    begin
                        if (echo_seen[i])
                        begin
                            total += 32'(echo_hist[i]);
                            cnt++;
                        end
                    end
                    range_us = ECHO_W'(total / cnt);
                    range_valid = 1'b1;
                    if (range_us < emerg_cfg && t.motor)
                        r.stop = 1'b1;
                end
                else
                begin
                    range_us = '0;
                    range_valid = 1'b0;
                end
            end
        end
        r.heading = heading_sum;
        r.avg = range_valid ? range_us : '0;
        r.rok = range_valid;
        return r;
    endfunction

    function automatic tick_in_t mk_tick(input int raw, input bit ok, input int elapsed,
                                         input int echo, input bit motor);
        tick_in_t t;
        t.raw = raw[GYRO_W-1:0];
        t.ok = ok;
        t.elapsed = elapsed[ELAPSED_W-1:0];
        t.echo = echo[ECHO_W-1:0];
        t.motor = motor;
        return t;
    endfunction

    function automatic tick_in_t random_tick();
        tick_in_t t;
        int pick;
        int tmp;
        t.raw = GYRO_W'($urandom);
        if ($urandom_range(0, 9) < 2)
        begin
            tmp = int'($urandom_range(0, 200)) - 100;
            t.raw = tmp[GYRO_W-1:0];
        end
        t.ok = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            t.elapsed = '0;
        else if (pick == 1)
            t.elapsed = ELAPSED_W'($urandom);
        else if (pick == 2)
            t.elapsed = 20'd1000000;
        else
            t.elapsed = ELAPSED_W'($urandom_range(1, 20000));
        pick = $urandom_range(0, 19);
        if (pick < 3)
            t.echo = '0;
        else if (pick < 5)
            t.echo = ECHO_W'($urandom);
        else if (pick < 9)
            t.echo = ECHO_W'($urandom_range(1, 400));
        else
            t.echo = ECHO_W'($urandom_range(1, 6000));
        t.motor = ($urandom_range(0, 1) != 0);
        return t;
    endfunction

    function automatic tick_in_t busy_tick();
        tick_in_t t;
        t = random_tick();
        if (t.elapsed == 0)
            t.elapsed = 20'd1;
        return t;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: %s got %0h, expected %0h", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        logic stall_next;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_ticks.size() == 0)
            begin
                report_mismatch("unexpected result heading", heading_acc, 64'd0);
            end
            else
            begin
                want = awaited_ticks.pop_front();
                if (heading_acc !== want.heading)
                    report_mismatch("heading_acc", heading_acc, want.heading);
                if (echo_avg_us !== want.avg)
                    report_mismatch("echo_avg_us", 64'(echo_avg_us), 64'(want.avg));
                if (range_ok !== want.rok)
                    report_mismatch("range_ok", 64'(range_ok), 64'(want.rok));
                if (stop_request !== want.stop)
                    report_mismatch("stop_request", 64'(stop_request), 64'(want.stop));
                if (sonar_step !== want.sonar)
                    report_mismatch("sonar_step", 64'(sonar_step), 64'(want.sonar));
            end
        end
        case (stall_mode)
            STALL_RANDOM:  stall_next = ($urandom_range(0, 99) < 35);
            STALL_PATTERN: stall_next = ((beat % 13) < 5);
            default:       stall_next = 1'b0;
        endcase
        out_stall <= hold_on || stall_next;
        beat <= beat + 1;
    end

    // The receiver holds off for a long stretch whenever a hold is requested.
    initial
    begin
        hold_on = 1'b0;
        forever
        begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    task automatic apb_write(input reg_index_t idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GYRO_BIAS: bias_cfg = longint'($signed(data[BIAS_W-1:0]));
            REG_DEADBAND:  deadband_cfg = data[DB_W-1:0];
            REG_EMERGENCY: emerg_cfg = data[ECHO_W-1:0];
            default:       ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_tick(input tick_in_t t);
        in_valid <= 1'b1;
        gyro_raw <= t.raw;
        gyro_ok <= t.ok;
        elapsed_us <= t.elapsed;
        echo_us <= t.echo;
        motor_running <= t.motor;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        awaited_ticks.push_back(filter_tick(t));
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_ticks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_tick(random_tick());
    endtask

    task automatic test_directed();
        stall_mode = STALL_NONE;
        gaps_on = 1'b0;
        send_tick(mk_tick(32767, 1, 1000000, 100, 1));
        send_tick(mk_tick(-32768, 1, 20'hFFFFF, 0, 0));
        send_tick(mk_tick(0, 0, 500, 13'h1FFF, 1));
        // A zero interval must leave the sonar schedule where it was.
        send_tick(mk_tick(123, 1, 0, 200, 1));
        send_tick(mk_tick(5, 1, 1, 0, 1));
        send_tick(mk_tick(-7, 0, 20, 150, 1));
        repeat (4) send_tick(busy_tick());
        send_tick(mk_tick(-1, 1, 0, 300, 1));
        send_tick(mk_tick(-1, 1, 7, 0, 1));
        repeat (4) send_tick(busy_tick());
        send_tick(mk_tick(1000, 1, 3000, 8191, 0));
        repeat (4) send_tick(busy_tick());
        send_tick(mk_tick(-1000, 1, 3000, 1, 1));
        settle();
    endtask

    task automatic test_bias_extremes();
        stall_mode = STALL_RANDOM;
        gaps_on = 1'b1;
        apb_write(REG_GYRO_BIAS, 32'hFFF8_0000);
        apb_write(REG_DEADBAND, 32'd524287);
        send_random(120);
        settle();
        apb_write(REG_GYRO_BIAS, 32'd524287);
        apb_write(REG_DEADBAND, 32'd0);
        send_random(120);
        settle();
    endtask

    task automatic test_threshold_extremes();
        stall_mode = STALL_PATTERN;
        gaps_on = 1'b1;
        apb_write(REG_GYRO_BIAS, 32'd0);
        apb_write(REG_EMERGENCY, 32'd0);
        send_random(120);
        settle();
        stall_mode = STALL_NONE;
        gaps_on = 1'b0;
        apb_write(REG_EMERGENCY, 32'hFFFF_FFFF);
        send_random(120);
        settle();
    endtask

    task automatic test_deadband_edge();
        int tmp;
        int target;
        tick_in_t t;
        stall_mode = STALL_RANDOM;
        gaps_on = 1'b1;
        tmp = int'($urandom_range(0, 8000)) - 4000;
        apb_write(REG_GYRO_BIAS, tmp);
        apb_write(REG_DEADBAND, $urandom_range(0, 4000));
        apb_write(REG_EMERGENCY, 32'd6000);
        repeat (150)
        begin
            t = busy_tick();
            t.ok = 1'b1;
            target = int'(bias_cfg) + ($urandom_range(0, 1) ? int'(deadband_cfg)
                                                              : -int'(deadband_cfg));
            tmp = target / 16 + int'($urandom_range(0, 4)) - 2;
            t.raw = tmp[GYRO_W-1:0];
            send_tick(t);
        end
        settle();
    endtask

    task automatic test_back_pressure();
        stall_mode = STALL_RANDOM;
        gaps_on = 1'b0;
        apb_write(REG_GYRO_BIAS, $urandom);
        apb_write(REG_DEADBAND, $urandom_range(0, 20000));
        apb_write(REG_EMERGENCY, 32'd2000);
        -> hold_go;
        send_random(150);
        -> hold_go;
        send_random(150);
        settle();
    endtask

    task automatic test_random_config();
        stall_mode = STALL_PATTERN;
        gaps_on = 1'b1;
        repeat (3)
        begin
            apb_write(REG_GYRO_BIAS, $urandom);
            apb_write(REG_DEADBAND, $urandom_range(0, 100000));
            apb_write(REG_EMERGENCY, $urandom_range(0, 6000));
            apb_write(REG_NONE, $urandom);
            send_random(120);
            settle();
            stall_mode = (stall_mode == STALL_PATTERN) ? STALL_RANDOM : STALL_PATTERN;
        end
    endtask

    initial
    begin
        clear_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_bias_extremes();
        test_threshold_extremes();
        test_deadband_edge();
        test_back_pressure();
        test_random_config();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
